// File: rtl/core/hierarchical_timer_wheel_unit_assert.svh
// assertion macros used by the timer wheel datapath
`ifndef HIERARCHICAL_TIMER_WHEEL_UNIT_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HTWU_ASSERT(lbl, c, r, p, msg) \
  lbl: assert property (@(posedge c) disable iff (r) p) else $error(msg);
`define HTWU_ASSERT_ALWAYS(lbl, c, p, msg) \
  lbl: assert property (@(posedge c) p) else $error(msg);
`else
`define HTWU_ASSERT(lbl, c, r, p, msg)
`define HTWU_ASSERT_ALWAYS(lbl, c, p, msg)
`endif
`endif

// File: rtl/core/htwu_pkg.sv
// types and constants of the timer wheel
`default_nettype none
package htwu_pkg;
  localparam int PTR_W = 7;
  localparam logic [PTR_W-1:0] NIL = 7'h7F;
  localparam int UPPER_LEVELS = 4;
  localparam int LVL_W = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] RK_ARMED   = 2'd0;
  localparam logic [1:0] RK_REJECT  = 2'd1;
  localparam logic [1:0] RK_EXPIRED = 2'd2;
  localparam logic [1:0] RK_NONE    = 2'd3;

  typedef struct packed {
    logic       clr_step;
    logic       take_in;
    logic       tick_inc;
    logic       lvl_clr;
    logic       lvl_inc;
    logic       any_clr;
    logic       arm_set;
    logic       slot_ld_place;
    logic       slot_ld_level;
    logic       slot_ld_root;
    logic       slot_rd;
    logic       slot_clr;
    logic       ap_nil;
    logic       ap_wr;
    logic       cur_from_head;
    logic       cur_next;
    logic       node_rd;
    logic       node_ld;
    logic       expire;
    logic       emit;
    logic [1:0] emit_kind;
  } htwu_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic reject;
    logic out_free;
    logic cur_nil;
    logic root_zero;
    logic li_zero;
    logic lvl_top;
    logic any;
  } htwu_status_t;
endpackage
`default_nettype wire

// File: rtl/core/htwu_ctrl.sv
// controller state machine of the timer wheel
`default_nettype none
module htwu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  htwu_pkg::htwu_status_t status,
  output htwu_pkg::htwu_cmd_t    cmd
);
  import htwu_pkg::*;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_ARM_CHK  = 5'd2;
  localparam logic [4:0] S_PL_SLOT  = 5'd3;
  localparam logic [4:0] S_AP_RD    = 5'd4;
  localparam logic [4:0] S_AP_WR    = 5'd5;
  localparam logic [4:0] S_ARM_EMIT = 5'd6;
  localparam logic [4:0] S_LVL      = 5'd7;
  localparam logic [4:0] S_CS_RD    = 5'd8;
  localparam logic [4:0] S_CS_HEAD  = 5'd9;
  localparam logic [4:0] S_CS_NEXT  = 5'd10;
  localparam logic [4:0] S_CS_LD    = 5'd11;
  localparam logic [4:0] S_CS_END   = 5'd12;
  localparam logic [4:0] S_DR_RD    = 5'd13;
  localparam logic [4:0] S_DR_HEAD  = 5'd14;
  localparam logic [4:0] S_DR_NEXT  = 5'd15;
  localparam logic [4:0] S_DR_EMIT  = 5'd16;
  localparam logic [4:0] S_NOEXP    = 5'd17;

  logic [4:0] state, state_next;
  logic       cas_mode, cas_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cas_mode <= 1'b0;
    end else begin
      state    <= state_next;
      cas_mode <= cas_mode_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    cas_mode_next = cas_mode;
    in_ready      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (in_kind) begin
            cmd.tick_inc = 1'b1;
            cmd.lvl_clr  = 1'b1;
            cmd.any_clr  = 1'b1;
            state_next   = S_LVL;
          end else begin
            state_next = S_ARM_CHK;
          end
        end
      end
      S_ARM_CHK: begin
        if (status.reject) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = RK_REJECT;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.arm_set   = 1'b1;
          cas_mode_next = 1'b0;
          state_next    = S_PL_SLOT;
        end
      end
      S_PL_SLOT: begin
        cmd.slot_ld_place = 1'b1;
        state_next        = S_AP_RD;
      end
      S_AP_RD: begin
        cmd.slot_rd = 1'b1;
        cmd.ap_nil  = 1'b1;
        state_next  = S_AP_WR;
      end
      S_AP_WR: begin
        cmd.ap_wr = 1'b1;
        if (cas_mode) begin
          cmd.cur_next = 1'b1;
          state_next   = S_CS_NEXT;
        end else begin
          state_next = S_ARM_EMIT;
        end
      end
      S_ARM_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RK_ARMED;
          state_next    = S_IDLE;
        end
      end
      S_LVL: begin
        if (!status.root_zero) begin
          cmd.slot_ld_root = 1'b1;
          state_next       = S_DR_RD;
        end else begin
          cmd.slot_ld_level = 1'b1;
          state_next        = S_CS_RD;
        end
      end
      S_CS_RD: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_CS_HEAD;
      end
      S_CS_HEAD: begin
        cmd.cur_from_head = 1'b1;
        cmd.slot_clr      = 1'b1;
        state_next        = S_CS_NEXT;
      end
      S_CS_NEXT: begin
        if (status.cur_nil) begin
          state_next = S_CS_END;
        end else begin
          cmd.node_rd = 1'b1;
          state_next  = S_CS_LD;
        end
      end
      S_CS_LD: begin
        cmd.node_ld   = 1'b1;
        cas_mode_next = 1'b1;
        state_next    = S_PL_SLOT;
      end
      S_CS_END: begin
        // climb while this level's index is also zero
        if (status.li_zero && !status.lvl_top) begin
          cmd.lvl_inc = 1'b1;
          state_next  = S_LVL;
        end else begin
          cmd.slot_ld_root = 1'b1;
          state_next       = S_DR_RD;
        end
      end
      S_DR_RD: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_DR_HEAD;
      end
      S_DR_HEAD: begin
        cmd.cur_from_head = 1'b1;
        cmd.slot_clr      = 1'b1;
        state_next        = S_DR_NEXT;
      end
      S_DR_NEXT: begin
        if (status.cur_nil) begin
          state_next = status.any ? S_IDLE : S_NOEXP;
        end else begin
          cmd.node_rd = 1'b1;
          state_next  = S_DR_EMIT;
        end
      end
      S_DR_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RK_EXPIRED;
          cmd.expire    = 1'b1;
          cmd.cur_next  = 1'b1;
          state_next    = S_DR_NEXT;
        end
      end
      S_NOEXP: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RK_NONE;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/htwu_datapath.sv
// slot lists, timer store, tick and result register of the timer wheel
`default_nettype none
`include "hierarchical_timer_wheel_unit_assert.svh"
module htwu_datapath #(
  parameter int ROOT_BITS   = 8,
  parameter int LEVEL_BITS  = 6,
  parameter int TIMER_COUNT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  htwu_pkg::htwu_cmd_t     cmd,
  output htwu_pkg::htwu_status_t  status,
  input  logic [5:0]             in_id,
  input  logic [31:0]            in_delay,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic [5:0]             out_id,
  output logic                   out_last,
  output logic [6:0]             out_pending,
  output logic [31:0]            out_tick
);
  import htwu_pkg::*;

  localparam int ROOT_SIZE  = 1 << ROOT_BITS;
  localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
  localparam int SLOT_TOTAL = ROOT_SIZE + UPPER_LEVELS * LEVEL_SIZE;
  localparam int SW = $clog2(SLOT_TOTAL);
  localparam int IW = $clog2(TIMER_COUNT);

  logic [2*PTR_W-1:0] slot_mem [SLOT_TOTAL];
  logic [PTR_W-1:0]   link_mem [TIMER_COUNT];
  logic [31:0]        exp_mem  [TIMER_COUNT];
  logic [2*PTR_W-1:0] slot_q;
  logic [PTR_W-1:0]   link_q;
  logic [31:0]        exp_q;

  logic [31:0]            tick;
  logic [6:0]             pending;
  logic [TIMER_COUNT-1:0] armed;
  logic [PTR_W-1:0]       cur;
  logic [31:0]            exp_r;
  logic [SW-1:0]          slot_r;
  logic [SW-1:0]          clr_cnt;
  logic [LVL_W-1:0]       lvl;
  logic                   any_exp;
  logic [5:0]             id_r;
  logic [31:0]            delay_r;

  logic [31:0]           gap;
  logic [31:0]           arm_exp;
  logic [SW-1:0]         place_slot;
  logic                  found;
  logic [LEVEL_BITS-1:0] lvl_idx;
  logic [SW-1:0]         lvl_slot;
  logic [PTR_W-1:0]      head, tail;
  logic                  slot_empty;
  logic                  slot_we;
  logic [SW-1:0]         slot_wa;
  logic [2*PTR_W-1:0]    slot_wd;
  logic [6:0]            pend_dec;
  logic                  out_free;

  assign gap        = exp_r - tick;
  assign arm_exp    = tick + ((delay_r == 32'd0) ? 32'd1 : delay_r);
  assign head       = slot_q[2*PTR_W-1:PTR_W];
  assign tail       = slot_q[PTR_W-1:0];
  assign slot_empty = (head == NIL);
  assign pend_dec   = (pending != 7'd0) ? pending - 7'd1 : pending;
  assign out_free   = !out_valid || out_ready;

  // level and slot for a timer from its distance to now
  always_comb begin
    place_slot = SW'(exp_r[ROOT_BITS-1:0]);
    found      = ((gap >> ROOT_BITS) == 32'd0);
    for (int l = 0; l < UPPER_LEVELS; l++) begin
      if (!found && (l == UPPER_LEVELS - 1 ||
          (({32'd0, gap} >> (ROOT_BITS + (l + 1) * LEVEL_BITS)) == 64'd0))) begin
        place_slot = SW'(ROOT_SIZE + l * LEVEL_SIZE) +
                     SW'(LEVEL_BITS'({32'd0, exp_r} >> (ROOT_BITS + l * LEVEL_BITS)));
        found = 1'b1;
      end
    end
  end

  // cascade slot of the current level
  always_comb begin
    lvl_idx  = '0;
    lvl_slot = '0;
    for (int l = 0; l < UPPER_LEVELS; l++) begin
      if (lvl == LVL_W'(l)) begin
        lvl_idx  = LEVEL_BITS'({32'd0, tick} >> (ROOT_BITS + l * LEVEL_BITS));
        lvl_slot = SW'(ROOT_SIZE + l * LEVEL_SIZE) + SW'(lvl_idx);
      end
    end
  end

  always_comb begin
    slot_we = cmd.clr_step || cmd.slot_clr || cmd.ap_wr;
    slot_wa = cmd.clr_step ? clr_cnt : slot_r;
    if (cmd.ap_wr) begin
      slot_wd = {(slot_empty ? cur : head), cur};
    end else begin
      slot_wd = {NIL, NIL};
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.slot_rd) slot_q <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ap_nil) begin
      link_mem[cur[IW-1:0]] <= NIL;
    end else if (cmd.ap_wr && !slot_empty) begin
      link_mem[tail[IW-1:0]] <= cur;
    end
    if (cmd.arm_set) exp_mem[id_r[IW-1:0]] <= arm_exp;
    if (cmd.node_rd) begin
      link_q <= link_mem[cur[IW-1:0]];
      exp_q  <= exp_mem[cur[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      pending   <= '0;
      armed     <= '0;
      clr_cnt   <= '0;
      lvl       <= '0;
      any_exp   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + SW'(1);
      if (cmd.tick_inc) tick <= tick + 32'd1;
      if (cmd.lvl_clr) begin
        lvl <= '0;
      end else if (cmd.lvl_inc) begin
        lvl <= lvl + LVL_W'(1);
      end
      if (cmd.any_clr) begin
        any_exp <= 1'b0;
      end else if (cmd.expire) begin
        any_exp <= 1'b1;
      end
      if (cmd.arm_set) begin
        armed[id_r[IW-1:0]] <= 1'b1;
        pending <= pending + 7'd1;
      end else if (cmd.expire) begin
        armed[cur[IW-1:0]] <= 1'b0;
        pending <= pend_dec;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      id_r    <= in_id;
      delay_r <= in_delay;
    end
    if (cmd.arm_set) begin
      cur   <= {1'b0, id_r};
      exp_r <= arm_exp;
    end else if (cmd.node_ld) begin
      exp_r <= exp_q;
    end else if (cmd.cur_from_head) begin
      cur <= head;
    end else if (cmd.cur_next) begin
      cur <= link_q;
    end
    if (cmd.slot_ld_place) begin
      slot_r <= place_slot;
    end else if (cmd.slot_ld_level) begin
      slot_r <= lvl_slot;
    end else if (cmd.slot_ld_root) begin
      slot_r <= SW'(tick[ROOT_BITS-1:0]);
    end
    if (cmd.emit) begin
      out_kind <= cmd.emit_kind;
      out_tick <= tick;
      unique case (cmd.emit_kind)
        RK_EXPIRED: begin
          out_id      <= cur[5:0];
          out_last    <= (link_q == NIL);
          out_pending <= pend_dec;
        end
        RK_NONE: begin
          out_id      <= 6'd0;
          out_last    <= 1'b1;
          out_pending <= pending;
        end
        default: begin
          out_id      <= id_r;
          out_last    <= 1'b1;
          out_pending <= pending;
        end
      endcase
    end
  end

  always_comb begin
    status.clear_last = (clr_cnt == SW'(SLOT_TOTAL - 1));
    status.reject     = ({1'b0, id_r} >= 7'(TIMER_COUNT)) || armed[id_r[IW-1:0]];
    status.out_free   = out_free;
    status.cur_nil    = (cur == NIL);
    status.root_zero  = (tick[ROOT_BITS-1:0] == '0);
    status.li_zero    = (lvl_idx == '0);
    status.lvl_top    = (lvl == LVL_W'(UPPER_LEVELS - 1));
    status.any        = any_exp;
  end

  `HTWU_ASSERT(a_pending_matches_armed, clk, rst, $countones(armed) == 32'(pending), "pending count differs from armed timers")
  `HTWU_ASSERT(a_emit_needs_room, clk, rst, cmd.emit |-> out_free, "result written over an untaken one")
  `HTWU_ASSERT(a_arm_counts, clk, rst, cmd.arm_set |=> pending == $past(pending) + 7'd1, "arm did not raise pending")
endmodule
`default_nettype wire

// File: rtl/core/hierarchical_timer_wheel_unit.sv
// top level of the hierarchical timer wheel
//
// channel  dir  tdata (low bit first)                      tuser        tlast
// s_axis   in   timer_id[5:0] delay_ticks[37:6] pad         kind         -
// m_axis   out  expired_id[5:0] pending[12:6] now_tick      result_kind  last
//
// an arm checks the id, places the timer and links it into its slot; a rejected
// arm answers at once. a tick gives a result per expired timer, or one of kind
// none if none expires; a root wrap first cascades the upper levels, moving each
// timer down (list walk, slot memory read then write). after reset a clearing
// pass writes every slot, one a cycle, with s_axis_tready low.
// one item is worked at a time; the result register lets the next item in
// while the last result waits, and work stalls only when a new result finds
// it still full.
`default_nettype none
module hierarchical_timer_wheel_unit #(
  parameter int ROOT_BITS   = 8,
  parameter int LEVEL_BITS  = 6,
  parameter int TIMER_COUNT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [htwu_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // timer_id, delay_ticks
  input  logic                               s_axis_tuser,  // kind
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [htwu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // expired_id, pending, now_tick
  output logic [1:0]                         m_axis_tuser,  // result_kind
  output logic                               m_axis_tlast
);
  import htwu_pkg::*;

  htwu_cmd_t    cmd;
  htwu_status_t status;
  logic [5:0]   out_id;
  logic [6:0]   out_pending;
  logic [31:0]  out_tick;

  htwu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  htwu_datapath #(
    .ROOT_BITS   (ROOT_BITS),
    .LEVEL_BITS  (LEVEL_BITS),
    .TIMER_COUNT (TIMER_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_id       (s_axis_tdata[5:0]),
    .in_delay    (s_axis_tdata[37:6]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_id      (out_id),
    .out_last    (m_axis_tlast),
    .out_pending (out_pending),
    .out_tick    (out_tick)
  );

  assign m_axis_tdata = {3'b000, out_tick, out_pending, out_id};
endmodule
`default_nettype wire
